/* src/lph_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

  localparam int SLOTS        = 256;
  localparam int RECORD_BYTES = 8;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = (SLOT_W + 1 > 9) ? SLOT_W + 1 : 9;
  localparam int SUM_W        = 11;
  localparam int MOD_W        = 9;
  localparam int STORED_MAX   = 511;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] REG_SLOT_COUNT   = 2'd0;
  localparam logic [1:0] REG_HASH_MODULUS = 2'd1;
  localparam logic [1:0] REG_KEY_OFFSET   = 2'd2;
  localparam logic [1:0] REG_KEY_LENGTH   = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [MOD_W-1:0] m;
    logic [7:0]       key_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [63:0]       rec;
    logic [SLOT_W-1:0] home;
  } job_t;

  function automatic logic [7:0] key_mask(input logic [2:0] off, input logic [3:0] len);
    logic [7:0] mk;
    int d;
    mk = '0;
    for (int i = 0; i < 8; i++) begin
      d = i - int'(off);
      mk[i] = (d >= 0) && (d < int'(len)) && (i < RECORD_BYTES);
    end
    return mk;
  endfunction

  function automatic logic [SUM_W-1:0] key_sum(input logic [63:0] rec, input logic [7:0] mk);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (mk[i]) s = s + SUM_W'(rec[8*i +: 8]);
    end
    return s;
  endfunction

  function automatic logic keys_eq(input logic [63:0] a, input logic [63:0] b,
                                   input logic [7:0] mk);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (mk[i] && (a[8*i +: 8] != b[8*i +: 8])) eq = 1'b0;
    end
    return eq;
  endfunction

  function automatic logic [63:0] rec_mask(input logic [63:0] rec);
    logic [63:0] mk;
    mk = (64'd1 << (8 * RECORD_BYTES)) - 64'd1;
    return rec & mk;
  endfunction

  // restoring remainder, up to four dividend bits, msb first
  function automatic logic [MOD_W-1:0] mod_chunk(input logic [MOD_W-1:0] r_in,
                                                 input logic [3:0] bits, input int cnt,
                                                 input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] r;
    logic [MOD_W:0]   t;
    r = r_in;
    for (int i = 3; i >= 0; i--) begin
      if (i < cnt) begin
        t = {r, bits[i]};
        if (t >= {1'b0, m}) t = t - {1'b0, m};
        r = t[MOD_W-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/lph_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lph_front import lph_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [63:0] in_record,
  output logic             push,
  output job_t             push_job,
  input  wire logic        q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       step_r;
  logic [1:0]       op_r;
  logic [63:0]      rec_r;
  logic [SUM_W-1:0] sum_r;
  logic [MOD_W-1:0] rem_r, rem_nxt;

  assign busy = (state_r != F_IDLE);
  assign push = (state_r == F_PUSH) && !q_full;
  assign push_job = '{op: op_r, rec: rec_r, home: SLOT_W'(rem_r)};

  always_comb begin
    case (step_r)
      2'd0:    rem_nxt = mod_chunk('0, sum_r[10:7], 4, cfg.m);
      2'd1:    rem_nxt = mod_chunk(rem_r, sum_r[6:3], 4, cfg.m);
      default: rem_nxt = mod_chunk(rem_r, {1'b0, sum_r[2:0]}, 3, cfg.m);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (start) state_nxt = F_MOD;
      F_MOD:   if (step_r == 2'd2) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_MOD) step_r <= step_r + 2'd1;
      else step_r <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      op_r  <= in_operation;
      rec_r <= in_record;
      sum_r <= key_sum(in_record, cfg.key_mask);
    end
    if (state_r == F_MOD) rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

/* src/lph_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module lph_queue import lph_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop) rptr_r <= !rptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_job;
  end

endmodule
`default_nettype wire

/* src/lph_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lph_back import lph_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire job_t  q_head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [63:0] out_found_record,
  output logic [7:0] out_slot_index
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_HC    = 2'd1;
  localparam logic [1:0] B_INS   = 2'd2;
  localparam logic [1:0] B_PROBE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  job_t              job_r;
  logic [SLOTS-1:0]  used_r;
  logic [CNT_W-1:0]  stored_r;
  logic [SLOT_W-1:0] s_r, s_wrap;
  logic [CNT_W-1:0]  k_r, dk_r;
  logic [7:0]        left_r, cnt_r, hc_val;

  // home counts: memory with per-entry valid bits
  logic [7:0]        hc_mem [SLOTS];
  logic [SLOTS-1:0]  hc_vld_r;
  logic [7:0]        hc_rd_r;
  logic              hc_rdv_r;
  logic              hc_we;
  logic [7:0]        hc_wdata;

  logic [63:0]       rec_mem [SLOTS];
  logic [63:0]       rec_rd_r;
  logic              rec_we;

  // probe pipeline
  logic              p0_vld_r, p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  logic [SLOT_W-1:0] p0_s_r, p1_s_r, p2_s_r, p3_s_r, p4_s_r;
  logic              p0_used_r, p1_used_r, p2_used_r, p3_used_r, p4_used_r;
  logic              p1_eq_r, p2_eq_r, p3_eq_r, p4_eq_r;
  logic [SUM_W-1:0]  p1_sum_r, p2_sum_r, p3_sum_r;
  logic [MOD_W-1:0]  p2_rem_r, p3_rem_r, p4_rem_r;
  logic [63:0]       p1_rec_r, p2_rec_r, p3_rec_r, p4_rec_r;

  logic hit_eq, same_home, probe_fin, pipe_en, issue;
  logic fin;
  logic [1:0]        fin_status;
  logic [63:0]       fin_found;
  logic [SLOT_W-1:0] fin_slot;
  logic ins_hit, del_hit;

  assign hc_val = hc_rdv_r ? hc_rd_r : 8'd0;
  assign s_wrap = ((CNT_W'(s_r) + CNT_W'(1)) >= cfg.n) ? '0 : s_r + SLOT_W'(1);
  assign pop    = (state_r == B_IDLE) && !q_empty;

  assign hit_eq    = p4_vld_r && p4_used_r && p4_eq_r;
  assign same_home = p4_vld_r && p4_used_r && !p4_eq_r && (SLOT_W'(p4_rem_r) == job_r.home);
  assign probe_fin = (state_r == B_PROBE) &&
                     (hit_eq || (same_home && left_r == 8'd1) ||
                      (p4_vld_r && (dk_r + CNT_W'(1) == cfg.n)));
  assign pipe_en   = (state_r == B_PROBE) && !probe_fin;
  assign issue     = pipe_en && (k_r < cfg.n);
  assign ins_hit   = (state_r == B_INS) && !used_r[s_r];
  assign del_hit   = probe_fin && hit_eq && (job_r.op == OP_DELETE);

  always_comb begin
    state_nxt  = state_r;
    fin        = 1'b0;
    fin_status = ST_MISS;
    fin_found  = '0;
    fin_slot   = '0;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_HC;
      B_HC: begin
        case (job_r.op)
          OP_INSERT: begin
            if (stored_r < cfg.n) state_nxt = B_INS;
            else begin
              fin = 1'b1;
              fin_status = ST_FULL;
            end
          end
          OP_FIND, OP_DELETE: begin
            if (hc_val != 8'd0) state_nxt = B_PROBE;
            else fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      B_INS: begin
        if (ins_hit) begin
          fin = 1'b1;
          fin_status = ST_OK;
          fin_slot = s_r;
        end else if (k_r + CNT_W'(1) >= cfg.n) begin
          fin = 1'b1;
          fin_status = ST_FULL;
        end
      end
      B_PROBE: begin
        if (probe_fin) begin
          fin = 1'b1;
          if (hit_eq) begin
            fin_status = ST_OK;
            fin_slot = p4_s_r;
            if (job_r.op == OP_FIND) fin_found = p4_rec_r;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (fin) state_nxt = B_IDLE;
  end

  always_comb begin
    hc_we    = 1'b0;
    hc_wdata = cnt_r;
    rec_we   = ins_hit;
    if (ins_hit) begin
      hc_we = 1'b1;
      hc_wdata = (cnt_r < 8'd255) ? cnt_r + 8'd1 : cnt_r;
    end else if (del_hit) begin
      hc_we = 1'b1;
      hc_wdata = (cnt_r > 8'd0) ? cnt_r - 8'd1 : cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      used_r    <= '0;
      stored_r  <= '0;
      hc_vld_r  <= '0;
      out_valid <= 1'b0;
      p0_vld_r  <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= fin;
      if (hc_we) hc_vld_r[job_r.home] <= 1'b1;
      if (ins_hit) begin
        used_r[s_r] <= 1'b1;
        if (stored_r < CNT_W'(STORED_MAX)) stored_r <= stored_r + CNT_W'(1);
      end
      if (del_hit) begin
        used_r[p4_s_r] <= 1'b0;
        if (stored_r != '0) stored_r <= stored_r - CNT_W'(1);
      end
      p0_vld_r <= issue;
      p1_vld_r <= pipe_en && p0_vld_r;
      p2_vld_r <= pipe_en && p1_vld_r;
      p3_vld_r <= pipe_en && p2_vld_r;
      p4_vld_r <= pipe_en && p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_head;
    hc_rd_r  <= hc_mem[q_head.home];
    hc_rdv_r <= hc_vld_r[q_head.home];
    if (hc_we) hc_mem[job_r.home] <= hc_wdata;
    rec_rd_r <= rec_mem[s_r];
    if (rec_we) rec_mem[s_r] <= rec_mask(job_r.rec);
  end

  always_ff @(posedge clk) begin
    if (state_r == B_HC) begin
      cnt_r  <= hc_val;
      left_r <= hc_val;
      s_r    <= job_r.home;
      k_r    <= '0;
      dk_r   <= '0;
    end else if (state_r == B_INS) begin
      s_r <= s_wrap;
      k_r <= k_r + CNT_W'(1);
    end else if (state_r == B_PROBE) begin
      if (issue) begin
        s_r <= s_wrap;
        k_r <= k_r + CNT_W'(1);
      end
      if (p4_vld_r) dk_r <= dk_r + CNT_W'(1);
      if (same_home) left_r <= left_r - 8'd1;
    end

    p0_s_r    <= s_r;
    p0_used_r <= used_r[s_r];

    p1_s_r    <= p0_s_r;
    p1_used_r <= p0_used_r;
    p1_eq_r   <= keys_eq(rec_rd_r, job_r.rec, cfg.key_mask);
    p1_sum_r  <= key_sum(rec_rd_r, cfg.key_mask);
    p1_rec_r  <= rec_rd_r;

    p2_s_r    <= p1_s_r;
    p2_used_r <= p1_used_r;
    p2_eq_r   <= p1_eq_r;
    p2_sum_r  <= p1_sum_r;
    p2_rec_r  <= p1_rec_r;
    p2_rem_r  <= mod_chunk('0, p1_sum_r[10:7], 4, cfg.m);

    p3_s_r    <= p2_s_r;
    p3_used_r <= p2_used_r;
    p3_eq_r   <= p2_eq_r;
    p3_sum_r  <= p2_sum_r;
    p3_rec_r  <= p2_rec_r;
    p3_rem_r  <= mod_chunk(p2_rem_r, p2_sum_r[6:3], 4, cfg.m);

    p4_s_r    <= p3_s_r;
    p4_used_r <= p3_used_r;
    p4_eq_r   <= p3_eq_r;
    p4_rec_r  <= p3_rec_r;
    p4_rem_r  <= mod_chunk(p3_rem_r, {1'b0, p3_sum_r[2:0]}, 3, cfg.m);

    out_status       <= fin_status;
    out_found_record <= fin_found;
    out_slot_index   <= 8'(fin_slot);
  end

endmodule
`default_nettype wire

/* src/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Linear-probing hash table. A command word (in_operation, in_record) is taken when start
// is high and busy is low; each command gives exactly one result word, shown for one
// cycle with out_valid, which the receiver must take on that cycle. The front hashes the
// key (byte sum modulo m) and hands the word to a two-deep queue, so busy drops again
// while the back still works. The back reads the home count, then an insert probes one
// slot a cycle (up to n slots, n = effective slot count); a find or delete streams one
// slot a cycle through a 5-stage compare and rehash pipeline, up to n slots. A busy
// table is therefore limited by the slot probe loop in the back.
// Configuration must be written only while the table is idle; the block does not check.
module linear_probe_hash_table import lph_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [63:0] in_record,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [63:0]      out_found_record,
  output logic [7:0]       out_slot_index,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [8:0] slot_count_r, hash_modulus_r;
  logic [2:0] key_offset_r;
  logic [3:0] key_length_r;
  cfg_t       cfg;
  logic [CNT_W-1:0] n_eff;
  logic [MOD_W-1:0] m_eff;

  logic push, q_full, q_empty, pop;
  job_t push_job, q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r   <= 9'd256;
      hash_modulus_r <= 9'd128;
      key_offset_r   <= 3'd0;
      key_length_r   <= 4'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SLOT_COUNT:   slot_count_r   <= pwdata[8:0];
        REG_HASH_MODULUS: hash_modulus_r <= pwdata[8:0];
        REG_KEY_OFFSET:   key_offset_r   <= pwdata[2:0];
        REG_KEY_LENGTH:   key_length_r   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLOT_COUNT:   prdata = {23'd0, slot_count_r};
      REG_HASH_MODULUS: prdata = {23'd0, hash_modulus_r};
      REG_KEY_OFFSET:   prdata = {29'd0, key_offset_r};
      REG_KEY_LENGTH:   prdata = {28'd0, key_length_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (slot_count_r == 9'd0) n_eff = CNT_W'(1);
    else if (int'(slot_count_r) > SLOTS) n_eff = CNT_W'(SLOTS);
    else n_eff = CNT_W'(slot_count_r);
    if (hash_modulus_r == 9'd0) m_eff = MOD_W'(1);
    else if (CNT_W'(hash_modulus_r) > n_eff) m_eff = MOD_W'(n_eff);
    else m_eff = hash_modulus_r;
  end

  assign cfg = '{n: n_eff, m: m_eff, key_mask: key_mask(key_offset_r, key_length_r)};

  lph_front u_front (
    .clk, .rst_n, .cfg, .start, .busy, .in_operation, .in_record,
    .push, .push_job, .q_full
  );

  lph_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .head(q_head), .full(q_full), .empty(q_empty)
  );

  lph_back u_back (
    .clk, .rst_n, .cfg, .q_head, .q_empty, .pop,
    .out_valid, .out_status, .out_found_record, .out_slot_index
  );

endmodule
`default_nettype wire
